// File: hw/rtl/sli_pkg.sv
// Shared types and constants for the sorted insertion list.
`default_nettype none

package sli_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_W     = 5;

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic                          kind;
		logic signed [VALUE_WIDTH-1:0] value;
	} sli_in_t;

	typedef struct packed {
		logic [1:0]                    status;
		logic [COUNT_W-1:0]            entry_count;
		logic signed [VALUE_WIDTH-1:0] front_value;
	} sli_out_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		logic                          ins_en;
		logic                          rem_en;
		logic signed [VALUE_WIDTH-1:0] value;
	} sli_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/sli_cell.sv
// One storage cell of the sorted list chain.
`default_nettype none

module sli_cell
	import sli_pkg::*;
(
	input  wire logic                          clk,
	input  wire sli_cmd_t                      cmd,
	input  wire logic                          occupied,
	input  wire logic                          left_gt,
	input  wire logic signed [VALUE_WIDTH-1:0] left_value,
	input  wire logic signed [VALUE_WIDTH-1:0] right_value,
	output logic                               gt,
	output logic                               eq,
	output logic signed [VALUE_WIDTH-1:0]      value_q
);

	assign gt = occupied && (value_q > cmd.value);
	assign eq = occupied && (value_q == cmd.value);

	// Cells at or behind the boundary move: insert pulls from the left,
	// remove pulls from the right.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !gt) begin
			value_q <= left_gt ? cmd.value : left_value;
		end else if (cmd.rem_en && !gt) begin
			value_q <= right_value;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_list_insert_remove.sv
// Top level of the sorted insertion list: a chain of compare-and-shift cells.
`default_nettype none

// Usage
//   Input channel: drive cmd (kind, value) and raise start; a transaction is
//   taken at a rising edge with start high and busy low. busy stays low: the
//   cell chain finishes any add or remove in the cycle it is taken, so one
//   transaction per cycle is sustained.
//   kind = add inserts value behind every larger stored value (ahead of
//   equals); kind = remove deletes the equal value nearest the front.
//   Result channel: done pulses for one cycle, in the cycle after the input
//   transaction, with status, the entry count after the transaction and the
//   largest stored value (zero when empty). The result is held in the cell
//   registers, the count register and the status register.
//   The receiver cannot stall; it must take the result in the done cycle.
//   Reset (arst_n low) empties the list and clears done. Cell contents are
//   not cleared; the entry count marks which cells hold data.
//   An add to a full list is dropped with status full; a remove of an absent
//   value leaves the list as it is with status not found.

module sorted_list_insert_remove
	import sli_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire sli_in_t cmd,
	output logic         done,
	output sli_out_t     result
);

	logic [COUNT_W-1:0]            count_q;
	logic [1:0]                    status_q;
	logic                          done_q;
	logic                          accept;
	logic                          full;
	logic                          found;
	logic [1:0]                    status_d;
	sli_cmd_t                      cell_cmd;
	logic [CAPACITY-1:0]           occ;
	logic [CAPACITY-1:0]           gt_vec;
	logic [CAPACITY-1:0]           eq_vec;
	logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];

	// Every transaction completes in the cycle it is taken, so never hold off start
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == COUNT_W'(CAPACITY));
	// List is sorted, so any match sits exactly at the insert boundary
	assign found  = |eq_vec;

	always_comb begin
		cell_cmd.value  = cmd.value;
		cell_cmd.ins_en = accept && (cmd.kind == KIND_ADD) && !full;
		cell_cmd.rem_en = accept && (cmd.kind == KIND_REMOVE) && found;
	end

	always_comb begin
		priority if (cmd.kind == KIND_ADD && full) begin
			status_d = ST_FULL;
		end else if (cmd.kind == KIND_REMOVE && !found) begin
			status_d = ST_NOT_FOUND;
		end else begin
			status_d = ST_DONE;
		end
	end

	// Cell chain: each cell sees its left neighbor's compare and both
	// neighbors' values
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                          left_gt;
		logic signed [VALUE_WIDTH-1:0] left_value;
		logic signed [VALUE_WIDTH-1:0] right_value;

		assign occ[i] = (COUNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_gt    = 1'b1;
			assign left_value = '0;
		end else begin : g_body
			assign left_gt    = gt_vec[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = '0;
		end else begin : g_mid
			assign right_value = cell_value[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.cmd         (cell_cmd),
			.occupied    (occ[i]),
			.left_gt     (left_gt),
			.left_value  (left_value),
			.right_value (right_value),
			.gt          (gt_vec[i]),
			.eq          (eq_vec[i]),
			.value_q     (cell_value[i])
		);
	end

	// Advance the count and register the status of each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_DONE;
			done_q   <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				status_q <= status_d;
			end
			if (cell_cmd.ins_en) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (cell_cmd.rem_en) begin
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end

	assign done               = done_q;
	assign result.status      = status_q;
	assign result.entry_count = count_q;
	assign result.front_value = (count_q != '0) ? cell_value[0] : '0;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == ST_FULL) |-> count_q == COUNT_W'(CAPACITY))
		else $error("full status with room left");

	a_not_found_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cell_cmd.ins_en && !cell_cmd.rem_en |=> $stable(count_q))
		else $error("count moved on a rejected transaction");

	a_front_order: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= COUNT_W'(2) |-> cell_value[0] >= cell_value[1])
		else $error("front cells out of order");

endmodule

`default_nettype wire
